### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the tokenizer design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence on the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg
// Types, character codes and token kinds shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package tlt_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] line;
        logic [31:0] start_pos;
        logic [15:0] length;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic      run_valid;
        logic      char_valid;
        t_out_item run_tok;
        t_out_item char_tok;
    } t_push;

    typedef enum logic [3:0] {
        RUN_NONE   = 4'b0001,
        RUN_LETTER = 4'b0010,
        RUN_DIGIT  = 4'b0100,
        RUN_OPER   = 4'b1000
    } t_run_kind;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [3:0] KIND_NUMBER  = 4'd0;
    localparam logic [3:0] KIND_IDENT   = 4'd1;
    localparam logic [3:0] KIND_OPER    = 4'd2;
    localparam logic [3:0] KIND_SEMI    = 4'd3;
    localparam logic [3:0] KIND_RPAREN  = 4'd4;
    localparam logic [3:0] KIND_LPAREN  = 4'd5;
    localparam logic [3:0] KIND_RBRACE  = 4'd6;
    localparam logic [3:0] KIND_LBRACE  = 4'd7;
    localparam logic [3:0] KIND_KEYWORD = 4'd8;
    localparam logic [3:0] KIND_END     = 4'd9;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;

    // Keywords packed first letter in the low byte.
    localparam logic [63:0] WORD_WHILE = 64'h0000_0065_6C69_6877;
    localparam logic [63:0] WORD_IF    = 64'h0000_0000_0000_6669;
    localparam int          LEN_WHILE  = 5;
    localparam int          LEN_IF     = 2;

    localparam int OUT_DEPTH = 4;

    function automatic t_run_kind classify(input logic [7:0] ch);
        t_run_kind k;
        k = RUN_NONE;
        if (ch inside {[8'h61:8'h7A], [8'h41:8'h5A]}) begin
            k = RUN_LETTER;
        end else if (ch inside {[8'h30:8'h39]}) begin
            k = RUN_DIGIT;
        end else if (ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                CH_EQUAL, CH_LESS, CH_GREATER}) begin
            k = RUN_OPER;
        end
        return k;
    endfunction

endpackage

### hdl/toy_language_tokenizer_core.sv
// ----------------------------------------------------------------------------
// toy_language_tokenizer_core
// Byte-serial lexical tokenizer with position-tagged token output.
// ----------------------------------------------------------------------------
// Input channel: one item per source byte (op = 0) or an end-of-input mark
// (op = 1), with valid/ready handshake. Output channel: token items carrying
// kind, line, start offset and length; last marks the final token of an item.
// An item is held in an input register until the queue has room, then its
// tokens are written to a four-entry result queue; the output is driven
// from the queue, so when the queue is empty the first token of an item is
// valid on the output as soon as it is written and can then be accepted.
// One input item is taken per cycle while the queue has room for two tokens.
// A byte that both ends a run and is a bracket or semicolon gives two tokens,
// which leave the queue one at a time; most bytes give zero or one.
// When the receiver stalls the queue fills and ready drops once three tokens
// wait in the queue and an item is held in the input register; no token is
// lost or repeated.
// Reset clears the run state, line and offset counters and the queue; an
// end-of-input item does the same to the run state after its end token.
// ----------------------------------------------------------------------------
module toy_language_tokenizer_core #(
    parameter int LONGEST_KEYWORD = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tlt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tlt_pkg::t_out_item o_out_item
);
    import tlt_pkg::*;

    logic      r_in_valid, n_in_valid;
    t_in_item  r_in_item;
    logic      space;
    logic      fire;
    t_push     push;

    always_comb begin
        fire       = r_in_valid && space;
        o_in_ready = !r_in_valid || fire;
        n_in_valid = (i_in_valid && o_in_ready) || (r_in_valid && !fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    tlt_lexer #(
        .LONGEST_KEYWORD(LONGEST_KEYWORD)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .o_push  (push)
    );

    tlt_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### hdl/tlt_lexer.sv
// ----------------------------------------------------------------------------
// tlt_lexer
// Run state of the tokenizer; turns one registered item into up to two tokens.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlt_lexer #(
    parameter int LONGEST_KEYWORD = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  tlt_pkg::t_in_item i_item,
    output tlt_pkg::t_push    o_push
);
    import tlt_pkg::*;

    localparam int WORD_W = 8 * LONGEST_KEYWORD;

    t_run_kind          r_kind,  n_kind;
    logic [31:0]        r_start, n_start;
    logic [15:0]        r_len,   n_len;
    logic [WORD_W-1:0]  r_word,  n_word;
    logic [15:0]        r_line,  n_line;
    logic [31:0]        r_pos,   n_pos;

    t_run_kind          cls;
    logic               is_end;
    logic               close_run;
    logic               new_run;
    logic               is_kw;
    logic [3:0]         run_tok_kind;
    logic [3:0]         punct_kind;
    logic               has_punct;
    logic               char_valid;
    logic [15:0]        base_len;
    logic [WORD_W-1:0]  base_word;

    always_comb begin
        cls       = classify(i_item.ch);
        is_end    = (i_item.op == OP_END);
        close_run = (r_kind != RUN_NONE) && (is_end || (cls != r_kind));
        new_run   = (cls != RUN_NONE) && (cls != r_kind);

        is_kw = ((LONGEST_KEYWORD >= LEN_WHILE) && (r_len == 16'(LEN_WHILE)) &&
                 (64'(r_word) == WORD_WHILE)) ||
                ((LONGEST_KEYWORD >= LEN_IF) && (r_len == 16'(LEN_IF)) &&
                 (64'(r_word) == WORD_IF));

        case (r_kind)
            RUN_LETTER: run_tok_kind = is_kw ? KIND_KEYWORD : KIND_IDENT;
            RUN_DIGIT:  run_tok_kind = KIND_NUMBER;
            default:    run_tok_kind = KIND_OPER;
        endcase

        has_punct  = 1'b1;
        case (i_item.ch)
            CH_SEMI:   punct_kind = KIND_SEMI;
            CH_RPAREN: punct_kind = KIND_RPAREN;
            CH_LPAREN: punct_kind = KIND_LPAREN;
            CH_RBRACE: punct_kind = KIND_RBRACE;
            CH_LBRACE: punct_kind = KIND_LBRACE;
            default: begin
                punct_kind = KIND_END;
                has_punct  = 1'b0;
            end
        endcase

        char_valid = is_end || has_punct;

        o_push.run_valid           = i_fire && close_run;
        o_push.char_valid          = i_fire && char_valid;
        o_push.run_tok.token_kind  = run_tok_kind;
        o_push.run_tok.line        = r_line;
        o_push.run_tok.start_pos   = r_start;
        o_push.run_tok.length      = r_len;
        o_push.run_tok.last        = !char_valid;
        o_push.char_tok.token_kind = is_end ? KIND_END : punct_kind;
        o_push.char_tok.line       = r_line;
        o_push.char_tok.start_pos  = r_pos;
        o_push.char_tok.length     = is_end ? 16'd0 : 16'd1;
        o_push.char_tok.last       = 1'b1;

        base_len  = new_run ? 16'd0 : r_len;
        base_word = new_run ? '0 : r_word;

        n_kind  = r_kind;
        n_start = r_start;
        n_len   = r_len;
        n_word  = r_word;
        n_line  = r_line;
        n_pos   = r_pos;

        if (i_fire) begin
            if (is_end) begin
                n_kind  = RUN_NONE;
                n_start = '0;
                n_len   = '0;
                n_word  = '0;
                n_line  = '0;
                n_pos   = '0;
            end else begin
                if (cls == RUN_NONE) begin
                    n_kind  = RUN_NONE;
                    n_start = '0;
                    n_len   = '0;
                    n_word  = '0;
                    if ((i_item.ch == CH_NEWLINE) && (r_line != 16'hFFFF)) begin
                        n_line = r_line + 16'd1;
                    end
                end else begin
                    n_kind  = cls;
                    n_start = new_run ? r_pos : r_start;
                    n_word  = base_word;
                    for (int k = 0; k < LONGEST_KEYWORD; k++) begin
                        if ((cls == RUN_LETTER) && (base_len == 16'(k))) begin
                            n_word[8*k +: 8] = i_item.ch;
                        end
                    end
                    n_len = (base_len != 16'hFFFF) ? base_len + 16'd1 : base_len;
                end
                if (r_pos != 32'hFFFF_FFFF) begin
                    n_pos = r_pos + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= RUN_NONE;
            r_start <= '0;
            r_len   <= '0;
            r_word  <= '0;
            r_line  <= '0;
            r_pos   <= '0;
        end else begin
            r_kind  <= n_kind;
            r_start <= n_start;
            r_len   <= n_len;
            r_word  <= n_word;
            r_line  <= n_line;
            r_pos   <= n_pos;
        end
    end

    `ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_fire && (i_item.op == OP_END),
        (r_kind == RUN_NONE) && (r_pos == 32'd0) && (r_line == 16'd0),
        "end item did not clear the run state")
    `ASSERT_ALWAYS(a_idle_empty, i_clk, i_rst_n,
        (r_kind == RUN_NONE) == ((r_len == 16'd0) && (r_word == '0)) ||
        ((r_kind != RUN_NONE) && (r_kind != RUN_LETTER) && (r_len != 16'd0)),
        "open run length and buffer disagree with run kind")
    `ASSERT_NEXT(a_break_closes, i_clk, i_rst_n,
        i_fire && (i_item.op == OP_BYTE) && (classify(i_item.ch) == RUN_NONE),
        r_kind == RUN_NONE, "separator byte left a run open")

endmodule

### hdl/tlt_out_queue.sv
// ----------------------------------------------------------------------------
// tlt_out_queue
// Small result queue; takes up to two tokens a cycle, hands out one a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlt_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlt_pkg::t_push     i_push,
    output logic               o_space,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tlt_pkg::t_out_item o_out_item
);
    import tlt_pkg::*;

    localparam int PW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    t_out_item         r_mem [OUT_DEPTH];
    logic [PW-1:0]     r_wptr, n_wptr;
    logic [PW-1:0]     r_rptr, n_rptr;
    logic [CW-1:0]     r_count, n_count;
    logic              pop;
    logic              any_push;
    t_out_item         first_tok;

    always_comb begin
        pop         = o_out_valid && i_out_ready;
        any_push    = i_push.run_valid || i_push.char_valid;
        first_tok   = i_push.run_valid ? i_push.run_tok : i_push.char_tok;
        o_out_valid = (r_count != '0);
        o_out_item  = r_mem[r_rptr];
        o_space     = (r_count <= CW'(OUT_DEPTH - 2));
        n_wptr      = r_wptr + PW'(i_push.run_valid) + PW'(i_push.char_valid);
        n_rptr      = pop ? r_rptr + PW'(1) : r_rptr;
        n_count     = r_count + CW'(i_push.run_valid) + CW'(i_push.char_valid)
                      - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (any_push) begin
            r_mem[r_wptr] <= first_tok;
        end
        if (i_push.run_valid && i_push.char_valid) begin
            r_mem[r_wptr + PW'(1)] <= i_push.char_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n,
        !any_push || (r_count <= CW'(OUT_DEPTH - 2)), "push into a full result queue")
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n,
        r_count <= CW'(OUT_DEPTH), "result count beyond queue depth")
    `ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, pop && !any_push,
        r_count == $past(r_count) - CW'(1), "pop without push did not drain one item")
    `ASSERT_ALWAYS(a_last_on_char, i_clk, i_rst_n,
        !i_push.char_valid || i_push.char_tok.last, "trailing token lacks last mark")

endmodule
